// File: rtl/srtd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srtd_pkg
// Types, codes and widths shared by the stream read terminator detector.
// ---------------------------------------------------------------------------
package srtd_pkg;

    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 16;
    localparam int ST_W       = 2;
    localparam int MODE_W     = 2;
    localparam int LEN_W      = 4;
    localparam int TOKEN_W    = 64;
    localparam int TSEL_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_EXACT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELIM   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOKEN   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

    localparam logic [ST_W-1:0] ST_SUCCESS  = 2'd0;
    localparam logic [ST_W-1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [ST_W-1:0] ST_INVALID  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_BYTES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 3'd4;

    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd10;

    typedef struct packed {
        logic              build;
        logic              match;
        logic [BYTE_W-1:0] data;
    } t_kmp_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } t_kmp_rsp;

    typedef struct packed {
        logic              store_valid;
        logic [IDX_W-1:0]  store_index;
        logic [BYTE_W-1:0] store_byte;
        logic              done_res;
        logic [ST_W-1:0]   status;
        logic [IDX_W-1:0]  byte_count;
        logic              term_seen;
    } t_result;

endpackage

// File: rtl/srtd_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srtd_in_if
// Input channel: one beat is a start, a received byte or a timeout.
// ---------------------------------------------------------------------------
interface srtd_in_if;
    import srtd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// File: rtl/srtd_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srtd_out_if
// Result channel: one beat per accepted input beat.
// ---------------------------------------------------------------------------
interface srtd_out_if;
    import srtd_pkg::*;

    logic              valid;
    logic              ready;
    logic              store_valid;
    logic [IDX_W-1:0]  store_index;
    logic [BYTE_W-1:0] store_byte;
    logic              done_res;
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  byte_count;
    logic              term_seen;

    modport source (
        output valid, output store_valid, output store_index, output store_byte,
        output done_res, output status, output byte_count, output term_seen,
        input  ready
    );
    modport sink (
        input  valid, input store_valid, input store_index, input store_byte,
        input  done_res, input status, input byte_count, input term_seen,
        output ready
    );
endinterface

// File: rtl/srtd_kmp_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srtd_kmp_unit
// Failure table build and token match around one shared byte comparator,
// one compare and at most one table access per cycle.
// ---------------------------------------------------------------------------
module srtd_kmp_unit #(
    parameter int MAX_TOKEN = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  srtd_pkg::t_kmp_req                  i_req,
    input  logic [srtd_pkg::LEN_W-1:0]          i_tlen,
    input  logic [srtd_pkg::TOKEN_W-1:0]        i_token,
    output srtd_pkg::t_kmp_rsp                  o_rsp
);
    import srtd_pkg::*;

    localparam int IW = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;

    typedef enum logic [1:0] {
        K_IDLE,
        K_BUILD,
        K_MATCH
    } t_kstate;

    t_kstate           r_state;
    logic [LEN_W-1:0]  r_i;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_ml;
    logic [BYTE_W-1:0] r_data;
    logic              r_done;
    logic              r_found;

    logic [LEN_W-1:0]  r_table [MAX_TOKEN];

    logic [TSEL_W-1:0] sel_a;
    logic [BYTE_W-1:0] cmp_a;
    logic [BYTE_W-1:0] cmp_b;
    logic              eq;
    logic [LEN_W-1:0]  fb_idx;
    logic [LEN_W-1:0]  fb_val;
    logic [LEN_W-1:0]  ml_inc;
    logic [LEN_W-1:0]  len_inc;

    logic              t_we;
    logic [IW-1:0]     t_addr;
    logic [LEN_W-1:0]  t_wdata;

    function automatic logic [BYTE_W-1:0] tok_at(logic [TOKEN_W-1:0] t, logic [TSEL_W-1:0] i);
        return t[{i, 3'b000} +: BYTE_W];
    endfunction

    // shared comparator
    always_comb begin
        sel_a   = (r_state == K_BUILD) ? r_i[TSEL_W-1:0] : r_ml[TSEL_W-1:0];
        cmp_a   = tok_at(i_token, sel_a);
        cmp_b   = (r_state == K_MATCH) ? r_data : tok_at(i_token, r_len[TSEL_W-1:0]);
        eq      = (cmp_a == cmp_b);
        fb_idx  = ((r_state == K_BUILD) ? r_len : r_ml) - LEN_W'(1);
        fb_val  = r_table[fb_idx[IW-1:0]];
        ml_inc  = r_ml + LEN_W'(1);
        len_inc = r_len + LEN_W'(1);
    end

    always_comb begin
        t_we    = 1'b0;
        t_addr  = r_i[IW-1:0];
        t_wdata = '0;
        if (r_state == K_IDLE && i_req.build) begin
            t_we   = 1'b1;
            t_addr = '0;
        end else if (r_state == K_BUILD && r_i < i_tlen) begin
            if (eq) begin
                t_we    = 1'b1;
                t_wdata = len_inc;
            end else if (r_len == '0) begin
                t_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_table[t_addr] <= t_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= K_IDLE;
            r_i     <= '0;
            r_len   <= '0;
            r_ml    <= '0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                K_IDLE: begin
                    if (i_req.build) begin
                        r_i     <= LEN_W'(1);
                        r_len   <= '0;
                        r_ml    <= '0;
                        r_state <= K_BUILD;
                    end else if (i_req.match) begin
                        r_data  <= i_req.data;
                        r_state <= K_MATCH;
                    end
                end
                K_BUILD: begin
                    if (r_i >= i_tlen) begin
                        r_done  <= 1'b1;
                        r_found <= 1'b0;
                        r_state <= K_IDLE;
                    end else if (eq) begin
                        r_len <= len_inc;
                        r_i   <= r_i + LEN_W'(1);
                    end else if (r_len != '0) begin
                        r_len <= fb_val;
                    end else begin
                        r_i <= r_i + LEN_W'(1);
                    end
                end
                K_MATCH: begin
                    if (r_ml != '0 && !eq) begin
                        r_ml <= fb_val;
                    end else begin
                        r_ml    <= eq ? ml_inc : r_ml;
                        r_found <= ((eq ? ml_inc : r_ml) >= i_tlen);
                        r_done  <= 1'b1;
                        r_state <= K_IDLE;
                    end
                end
                default: r_state <= K_IDLE;
            endcase
        end
    end

    assign o_rsp.busy  = (r_state != K_IDLE);
    assign o_rsp.done  = r_done;
    assign o_rsp.found = r_found;

endmodule

// File: rtl/stream_read_terminator_detector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stream_read_terminator_detector
// Read control for exact, delimiter and token terminated reads.
//
//   channel   dir   beat                               handshake
//   i_in      in    kind, data_byte                    valid/ready
//   o_out     out   store, done, status, count, found  valid/ready
//   i_cfg_*   in    register index, data               write enable only
//
// Timeout, exact or delimiter byte beats and starts that build no table go
// straight to the output state; a token byte beat waits in the KMP state for
// the match with its failure fallbacks, a token start for the table build.
// Reset is synchronous; no clearing pass, the failure table is written at start.
// A stalled output holds the block in its output state; a new beat is taken
// while the last result still waits.
// ---------------------------------------------------------------------------
module stream_read_terminator_detector #(
    parameter int MAX_TOKEN = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    srtd_in_if.sink                          i_in,
    srtd_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [srtd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srtd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import srtd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KMP,
        S_OUT
    } t_state;

    t_state            r_state;

    logic [MODE_W-1:0]  r_cfg_mode;
    logic [BYTE_W-1:0]  r_cfg_delim;
    logic [LEN_W-1:0]   r_cfg_tlen;
    logic [TOKEN_W-1:0] r_cfg_token;
    logic [IDX_W-1:0]   r_cfg_cap;

    logic [MODE_W-1:0]  r_h_mode;
    logic [BYTE_W-1:0]  r_h_delim;
    logic [LEN_W-1:0]   r_h_tlen;
    logic [TOKEN_W-1:0] r_h_token;
    logic [IDX_W-1:0]   r_h_cap;

    logic               r_active;
    logic [IDX_W-1:0]   r_pos;
    logic               r_kmp_match;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    t_result            n_res;
    logic [IDX_W-1:0]   n_pos;
    logic               n_active;
    logic               n_build;
    logic               n_match;
    logic [IDX_W:0]     pos_inc;
    logic               in_fire;

    t_kmp_req           kmp_req;
    t_kmp_rsp           kmp_rsp;

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign pos_inc    = {1'b0, r_pos} + (IDX_W+1)'(1);

    always_comb begin
        n_res            = '0;
        n_res.byte_count = (r_h_mode == MODE_TOKEN) ? '0 : r_pos;
        n_pos            = r_pos;
        n_active         = r_active;
        n_build          = 1'b0;
        n_match          = 1'b0;
        case (i_in.kind)
            KIND_START: begin
                n_pos            = '0;
                n_active         = 1'b0;
                n_res.byte_count = '0;
                if (r_cfg_cap == '0) begin
                    n_res.done_res = 1'b1;
                    n_res.status   = ST_SUCCESS;
                end else if (r_cfg_mode == MODE_INVALID) begin
                    n_res.done_res = 1'b1;
                    n_res.status   = ST_INVALID;
                end else if (r_cfg_mode == MODE_DELIM && r_cfg_cap < IDX_W'(2)) begin
                    n_res.done_res = 1'b1;
                    n_res.status   = ST_INVALID;
                end else if (r_cfg_mode == MODE_TOKEN &&
                             (r_cfg_tlen == '0 || r_cfg_tlen > LEN_W'(MAX_TOKEN))) begin
                    n_res.done_res = 1'b1;
                    n_res.status   = ST_INVALID;
                end else begin
                    n_active = 1'b1;
                    n_build  = (r_cfg_mode == MODE_TOKEN);
                end
            end
            KIND_BYTE: begin
                if (r_active) begin
                    case (r_h_mode)
                        MODE_EXACT: begin
                            n_res.store_valid = 1'b1;
                            n_res.store_index = r_pos;
                            n_res.store_byte  = i_in.data_byte;
                            n_pos             = pos_inc[IDX_W-1:0];
                            n_res.byte_count  = pos_inc[IDX_W-1:0];
                            if (pos_inc >= {1'b0, r_h_cap}) begin
                                n_res.done_res = 1'b1;
                                n_res.status   = ST_SUCCESS;
                                n_active       = 1'b0;
                            end
                        end
                        MODE_DELIM: begin
                            n_res.store_valid = 1'b1;
                            n_res.store_index = r_pos;
                            if (i_in.data_byte == r_h_delim) begin
                                n_res.store_byte = '0;
                                n_res.done_res   = 1'b1;
                                n_res.status     = ST_SUCCESS;
                                n_res.term_seen  = 1'b1;
                                n_active         = 1'b0;
                            end else begin
                                n_res.store_byte = i_in.data_byte;
                                n_pos            = pos_inc[IDX_W-1:0];
                                n_res.byte_count = pos_inc[IDX_W-1:0];
                                if (pos_inc >= {1'b0, r_h_cap} - (IDX_W+1)'(1)) begin
                                    n_res.done_res = 1'b1;
                                    n_res.status   = ST_OVERFLOW;
                                    n_active       = 1'b0;
                                end
                            end
                        end
                        default: n_match = 1'b1;
                    endcase
                end
            end
            KIND_TIMEOUT: begin
                if (r_active) begin
                    n_res.done_res = 1'b1;
                    n_res.status   = ST_TIMEOUT;
                    n_active       = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign kmp_req.build = in_fire && n_build;
    assign kmp_req.match = in_fire && n_match;
    assign kmp_req.data  = i_in.data_byte;

    srtd_kmp_unit #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_kmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (kmp_req),
        .i_tlen  (r_h_tlen),
        .i_token (r_h_token),
        .o_rsp   (kmp_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_mode  <= MODE_EXACT;
            r_cfg_delim <= DELIM_RESET;
            r_cfg_tlen  <= '0;
            r_cfg_token <= '0;
            r_cfg_cap   <= '0;
            r_h_mode    <= MODE_EXACT;
            r_h_delim   <= '0;
            r_h_tlen    <= '0;
            r_h_token   <= '0;
            r_h_cap     <= '0;
            r_active    <= 1'b0;
            r_pos       <= '0;
            r_kmp_match <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_READ_MODE:   r_cfg_mode  <= i_cfg_data[MODE_W-1:0];
                    CFG_DELIMITER:   r_cfg_delim <= i_cfg_data[BYTE_W-1:0];
                    CFG_TOKEN_LEN:   r_cfg_tlen  <= i_cfg_data[LEN_W-1:0];
                    CFG_TOKEN_BYTES: r_cfg_token <= i_cfg_data[TOKEN_W-1:0];
                    CFG_CAPACITY:    r_cfg_cap   <= i_cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_res    <= n_res;
                        r_pos    <= n_pos;
                        r_active <= n_active;
                        if (i_in.kind == KIND_START) begin
                            r_h_mode  <= r_cfg_mode;
                            r_h_delim <= r_cfg_delim;
                            r_h_tlen  <= r_cfg_tlen;
                            r_h_token <= r_cfg_token;
                            r_h_cap   <= r_cfg_cap;
                        end
                        r_kmp_match <= n_match;
                        r_state     <= (n_build || n_match) ? S_KMP : S_OUT;
                    end
                end
                S_KMP: begin
                    if (kmp_rsp.done) begin
                        if (r_kmp_match) begin
                            r_res.done_res  <= kmp_rsp.found;
                            r_res.term_seen <= kmp_rsp.found;
                            r_active        <= !kmp_rsp.found;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.store_valid = r_out.store_valid;
    assign o_out.store_index = r_out.store_index;
    assign o_out.store_byte  = r_out.store_byte;
    assign o_out.done_res    = r_out.done_res;
    assign o_out.status      = r_out.status;
    assign o_out.byte_count  = r_out.byte_count;
    assign o_out.term_seen   = r_out.term_seen;

    a_ready_kmp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !kmp_rsp.busy)
        else $error("input ready while KMP unit busy");

    a_kmp_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KMP && kmp_rsp.done) |=> (r_state == S_OUT))
        else $error("KMP completion not forwarded to output");

    a_timeout_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.done_res && o_out.status == ST_TIMEOUT)
            |-> (!o_out.store_valid && !o_out.term_seen))
        else $error("timeout result carries a store or terminator");

endmodule
